// ===== rtl/mec_pkg.sv =====
package mec_pkg;

   localparam int R2_W   = 35;
   localparam int P_W    = 37;
   localparam int ACC_W  = 54;
   localparam int DEN_W  = 36;
   localparam int Q_W    = 17;
   localparam int ROOT_W = 18;

   localparam logic [R2_W-1:0] INFINITY = 35'h3_FFFF_FFFF;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        radius;
      logic               found;
   } rsp_type;

   typedef enum logic [5:0] {
      S_LOAD, S_START, S_ONE, S_ONE_B,
      S_PR_A, S_PR_B, S_PR_C, S_PR_D, S_PR_E, S_PR_F, S_PR_G,
      S_CHK, S_CK_A, S_CK_B, S_CK_C, S_NEXT,
      S_TR_A, S_TR_B, S_TR_C, S_TR_D, S_TR_E, S_TR_F, S_TR_G, S_TR_H,
      S_TR_I, S_TR_J, S_TR_K, S_TR_L, S_TR_M, S_TR_N, S_TR_O, S_TR_P,
      S_TR_Q, S_TR_R, S_TR_S, S_TR_T, S_TR_U, S_TR_V,
      S_SQRT, S_SQ_W, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_DI, MUL_DJ, MUL_DK, MUL_DM, MUL_B, MUL_C, MUL_D,
      MUL_NXH, MUL_NXL, MUL_NYH, MUL_NYL
   } mul_op_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_HI, ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       ld_i;
      logic       ld_j;
      logic       ld_k;
      mul_op_type mul_op;
      acc_op_type acc_op;
      logic       b_ld;
      logic       c_ld;
      logic       d_ld;
      logic       r2_ld;
      logic       r2_max;
      logic       cand_pair;
      logic       cand_x_ld;
      logic       cand_y_ld;
      logic       div_start;
      logic       best_clr;
      logic       best_one;
      logic       best_upd;
      logic       sqrt_start;
      logic       rsp_ld;
   } cmd_type;

   typedef struct packed {
      logic d_zero;
      logic cand_ok;
      logic r2_lt_best;
      logic p_gt_r2;
      logic div_busy;
      logic sqrt_busy;
   } sts_type;

endpackage

// ===== rtl/mec_ram.sv =====
module mec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mec_div.sv =====
module mec_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mec_pkg::ACC_W-1:0]  num,
   input  logic [mec_pkg::DEN_W-1:0]  den,
   output logic                       busy,
   output logic [mec_pkg::Q_W-1:0]    quot,
   output logic                       ovf
);

   localparam int AW = mec_pkg::ACC_W;
   localparam int QW = mec_pkg::Q_W;
   localparam int SW = mec_pkg::DEN_W + QW - 1;

   logic [AW-1:0] rem_ff;
   logic [SW-1:0] dsh_ff;
   logic [QW-1:0] q_ff;
   logic          ovf_ff;
   logic [4:0]    cnt_ff;
   logic          busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'(QW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 5'd1;
         busy_ff <= (cnt_ff != 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ovf_ff <= (num >= AW'({den, {QW{1'b0}}}));
         rem_ff <= num;
         dsh_ff <= {den, {(QW-1){1'b0}}};
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (rem_ff >= AW'(dsh_ff)) begin
            rem_ff <= rem_ff - AW'(dsh_ff);
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign busy = busy_ff;
   assign quot = q_ff;
   assign ovf  = ovf_ff;

endmodule

// ===== rtl/mec_sqrt.sv =====
module mec_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mec_pkg::R2_W-1:0] value,
   output logic                     busy,
   output logic [15:0]              root
);

   localparam int RW = mec_pkg::ROOT_W;

   logic [2*RW-1:0] v_ff;
   logic [20:0]     rem_ff;
   logic [RW-1:0]   root_ff;
   logic [4:0]      cnt_ff;
   logic            busy_ff;
   logic [22:0]     part;
   logic [22:0]     trial;
   logic [RW:0]     rnd;

   assign part  = {rem_ff, v_ff[2*RW-1:2*RW-2]};
   assign trial = 23'({root_ff, 2'b01});
   assign rnd   = (RW+1)'(root_ff) + (RW+1)'(rem_ff > 21'(root_ff));
   assign root  = (rnd > (RW+1)'(16'hFFFF)) ? 16'hFFFF : rnd[15:0];
   assign busy  = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'(RW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 5'd1;
         busy_ff <= (cnt_ff != 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= (2*RW)'(value);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_ff <= v_ff << 2;
         if (part >= trial) begin
            rem_ff  <= 21'(part - trial);
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= 21'(part);
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end

endmodule

// ===== rtl/mec_dp.sv =====
module mec_dp #(
   parameter int MAX_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mec_pkg::cmd_type              cmd,
   output mec_pkg::sts_type              sts,
   input  mec_pkg::req_type              req_data,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
   output mec_pkg::rsp_type              rsp_data
);

   localparam int R2W = mec_pkg::R2_W;
   localparam int PW  = mec_pkg::P_W;
   localparam int AW  = mec_pkg::ACC_W;

   function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
      sx17 = {v[15], v};
   endfunction

   function automatic logic signed [17:0] sx18(input logic signed [16:0] v);
      sx18 = {v[16], v};
   endfunction

   function automatic logic [15:0] half_round(input logic signed [16:0] s);
      logic [16:0] mag;
      logic [17:0] h;
      mag = s[16] ? 17'(-s) : 17'(s);
      h = (18'(mag) + 18'd1) >> 1;
      half_round = s[16] ? 16'(-h) : 16'(h);
   endfunction

   logic [31:0]         rd_data;
   logic signed [15:0]  rd_x, rd_y;
   logic signed [15:0]  pi_x_ff, pi_y_ff, pj_x_ff, pj_y_ff, pk_x_ff, pk_y_ff;
   logic signed [15:0]  cand_x_ff, cand_y_ff;
   logic [R2W-1:0]      cand_r2_ff;
   logic                cand_ok_ff;
   logic [33:0]         b_ff, c_ff;
   logic signed [34:0]  d_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [PW-1:0] p_ff;
   logic signed [15:0]  best_x_ff, best_y_ff;
   logic [R2W-1:0]      best_r2_ff;
   logic                best_found_ff;
   mec_pkg::rsp_type    rsp_data_ff;

   logic signed [15:0]  tx, ty;
   logic signed [16:0]  dx, dy, bx, by, qx, qy;
   logic signed [17:0]  bh, bl, ch, cl;
   logic signed [17:0]  m0a, m0b, m1a, m1b;
   logic signed [35:0]  pr0, pr1;
   logic [AW-1:0]       acc_mag;
   logic [33:0]         d_mag;
   logic [AW-1:0]       div_num;
   logic [mec_pkg::DEN_W-1:0] div_den;
   logic                div_neg;
   logic                div_busy, div_ovf;
   logic [mec_pkg::Q_W-1:0] quot;
   logic signed [18:0]  qs, cbase, csum;
   logic                c_ok;
   logic                sqrt_busy;
   logic [15:0]         radius;

   mec_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.point_x, req_data.point_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[31:16];
   assign rd_y = rd_data[15:0];

   always_comb begin
      tx = pi_x_ff;
      ty = pi_y_ff;
      case (cmd.mul_op)
         mec_pkg::MUL_DJ: begin
            tx = pj_x_ff;
            ty = pj_y_ff;
         end
         mec_pkg::MUL_DK: begin
            tx = pk_x_ff;
            ty = pk_y_ff;
         end
         mec_pkg::MUL_DM: begin
            tx = rd_x;
            ty = rd_y;
         end
         default: ;
      endcase
   end

   assign dx = sx17(tx) - sx17(cand_x_ff);
   assign dy = sx17(ty) - sx17(cand_y_ff);
   assign bx = sx17(pj_x_ff) - sx17(pi_x_ff);
   assign by = sx17(pj_y_ff) - sx17(pi_y_ff);
   assign qx = sx17(pk_x_ff) - sx17(pi_x_ff);
   assign qy = sx17(pk_y_ff) - sx17(pi_y_ff);
   assign bh = {1'b0, b_ff[33:17]};
   assign bl = {1'b0, b_ff[16:0]};
   assign ch = {1'b0, c_ff[33:17]};
   assign cl = {1'b0, c_ff[16:0]};

   always_comb begin
      m0a = '0;
      m0b = '0;
      m1a = '0;
      m1b = '0;
      case (cmd.mul_op) inside
         mec_pkg::MUL_DI, mec_pkg::MUL_DJ, mec_pkg::MUL_DK, mec_pkg::MUL_DM: begin
            m0a = sx18(dx); m0b = sx18(dx); m1a = sx18(dy); m1b = sx18(dy);
         end
         mec_pkg::MUL_B: begin
            m0a = sx18(bx); m0b = sx18(bx); m1a = sx18(by); m1b = sx18(by);
         end
         mec_pkg::MUL_C: begin
            m0a = sx18(qx); m0b = sx18(qx); m1a = sx18(qy); m1b = sx18(qy);
         end
         mec_pkg::MUL_D: begin
            m0a = sx18(bx); m0b = sx18(qy); m1a = sx18(by); m1b = -sx18(qx);
         end
         mec_pkg::MUL_NXH: begin
            m0a = sx18(qy); m0b = bh; m1a = sx18(by); m1b = -ch;
         end
         mec_pkg::MUL_NXL: begin
            m0a = sx18(qy); m0b = bl; m1a = sx18(by); m1b = -cl;
         end
         mec_pkg::MUL_NYH: begin
            m0a = sx18(bx); m0b = ch; m1a = sx18(qx); m1b = -bh;
         end
         mec_pkg::MUL_NYL: begin
            m0a = sx18(bx); m0b = cl; m1a = sx18(qx); m1b = -bl;
         end
         default: ;
      endcase
   end

   assign pr0 = m0a * m0b;
   assign pr1 = m1a * m1b;

   assign acc_mag = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign d_mag   = d_ff[34] ? 34'(-d_ff) : 34'(d_ff);
   assign div_num = acc_mag + AW'(d_mag);
   assign div_den = {1'b0, d_mag, 1'b0};
   assign div_neg = acc_ff[AW-1] ^ d_ff[34];

   mec_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (quot),
      .ovf   (div_ovf)
   );

   assign qs    = div_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
   assign cbase = cmd.cand_y_ld ? 19'(pi_y_ff) : 19'(pi_x_ff);
   assign csum  = cbase + qs;
   assign c_ok  = !div_ovf && (csum[18:15] == 4'b0000 || csum[18:15] == 4'b1111);

   mec_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (best_r2_ff),
      .busy  (sqrt_busy),
      .root  (radius)
   );

   always_ff @(posedge clock) begin
      p_ff <= PW'(pr0) + PW'(pr1);
      if (cmd.ld_i) begin
         pi_x_ff <= rd_x;
         pi_y_ff <= rd_y;
      end
      if (cmd.ld_j) begin
         pj_x_ff <= rd_x;
         pj_y_ff <= rd_y;
      end
      if (cmd.ld_k) begin
         pk_x_ff <= rd_x;
         pk_y_ff <= rd_y;
      end
      if (cmd.b_ld) b_ff <= p_ff[33:0];
      if (cmd.c_ld) c_ff <= p_ff[33:0];
      if (cmd.d_ld) d_ff <= p_ff[34:0];
      case (cmd.acc_op)
         mec_pkg::ACC_HI:  acc_ff <= AW'(p_ff) <<< 17;
         mec_pkg::ACC_ADD: acc_ff <= acc_ff + AW'(p_ff);
         default: ;
      endcase
      if (cmd.r2_ld) begin
         cand_r2_ff <= p_ff[R2W-1:0];
      end else if (cmd.r2_max && p_ff[R2W-1:0] > cand_r2_ff) begin
         cand_r2_ff <= p_ff[R2W-1:0];
      end
      if (cmd.cand_pair) begin
         cand_x_ff <= half_round(sx17(pi_x_ff) + sx17(pj_x_ff));
         cand_y_ff <= half_round(sx17(pi_y_ff) + sx17(pj_y_ff));
      end
      if (cmd.cand_x_ld) begin
         cand_x_ff  <= csum[15:0];
         cand_ok_ff <= c_ok;
      end
      if (cmd.cand_y_ld) begin
         cand_y_ff  <= csum[15:0];
         cand_ok_ff <= c_ok;
      end
      if (cmd.rsp_ld) begin
         if (best_found_ff) begin
            rsp_data_ff.center_x <= best_x_ff;
            rsp_data_ff.center_y <= best_y_ff;
            rsp_data_ff.radius   <= radius;
            rsp_data_ff.found    <= 1'b1;
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.best_clr) begin
         best_found_ff <= 1'b0;
         best_r2_ff    <= mec_pkg::INFINITY;
         best_x_ff     <= '0;
         best_y_ff     <= '0;
      end else if (cmd.best_one) begin
         best_found_ff <= 1'b1;
         best_r2_ff    <= '0;
         best_x_ff     <= pi_x_ff;
         best_y_ff     <= pi_y_ff;
      end else if (cmd.best_upd) begin
         best_found_ff <= 1'b1;
         best_r2_ff    <= cand_r2_ff;
         best_x_ff     <= cand_x_ff;
         best_y_ff     <= cand_y_ff;
      end
   end

   assign sts.d_zero     = (d_ff == '0);
   assign sts.cand_ok    = cand_ok_ff;
   assign sts.r2_lt_best = (cand_r2_ff < best_r2_ff);
   assign sts.p_gt_r2    = (p_ff[R2W-1:0] > cand_r2_ff);
   assign sts.div_busy   = div_busy;
   assign sts.sqrt_busy  = sqrt_busy;
   assign rsp_data       = rsp_data_ff;

   a_best_inf: assert property (@(posedge clock) disable iff (reset)
      !best_found_ff |-> best_r2_ff == mec_pkg::INFINITY)
      else $error("best radius set without a found circle");

endmodule

// ===== rtl/mec_ctrl.sv =====
module mec_ctrl #(
   parameter int MAX_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_last,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mec_pkg::cmd_type              cmd,
   input  mec_pkg::sts_type              sts,
   output logic                          wr_en,
   output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   output logic [$clog2(MAX_POINTS)-1:0] rd_addr
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AW = CW + 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

   mec_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, m_ff, m_in;
   logic          tri_ff, tri_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] cnt_w, i_w, j_w, k_w, m_w;
   logic          m_last;

   assign cnt_w  = AW'(count_ff);
   assign i_w    = AW'(i_ff);
   assign j_w    = AW'(j_ff);
   assign k_w    = AW'(k_ff);
   assign m_w    = AW'(m_ff);
   assign m_last = (m_w + AW'(1) == cnt_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mec_pkg::S_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tri_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         tri_ff       <= tri_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      m_ff <= m_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      tri_in       = tri_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         mec_pkg::S_LOAD: begin
            if (req_valid) begin
               if (count_ff < MAX_CNT) count_in = count_ff + CW'(1);
               if (req_last) state_in = mec_pkg::S_START;
            end
         end
         mec_pkg::S_START: begin
            i_in   = '0;
            j_in   = IW'(1);
            tri_in = 1'b0;
            state_in = (count_ff == CW'(1)) ? mec_pkg::S_ONE : mec_pkg::S_PR_A;
         end
         mec_pkg::S_ONE:   state_in = mec_pkg::S_ONE_B;
         mec_pkg::S_ONE_B: state_in = mec_pkg::S_SQRT;
         mec_pkg::S_PR_A:  state_in = mec_pkg::S_PR_B;
         mec_pkg::S_PR_B:  state_in = mec_pkg::S_PR_C;
         mec_pkg::S_PR_C:  state_in = mec_pkg::S_PR_D;
         mec_pkg::S_PR_D:  state_in = mec_pkg::S_PR_E;
         mec_pkg::S_PR_E:  state_in = mec_pkg::S_PR_F;
         mec_pkg::S_PR_F:  state_in = mec_pkg::S_PR_G;
         mec_pkg::S_PR_G:  state_in = mec_pkg::S_CHK;
         mec_pkg::S_CHK: begin
            m_in = '0;
            state_in = sts.r2_lt_best ? mec_pkg::S_CK_A : mec_pkg::S_NEXT;
         end
         mec_pkg::S_CK_A: state_in = mec_pkg::S_CK_B;
         mec_pkg::S_CK_B: state_in = mec_pkg::S_CK_C;
         mec_pkg::S_CK_C: begin
            if (sts.p_gt_r2 || m_last) begin
               state_in = mec_pkg::S_NEXT;
            end else begin
               m_in = m_ff + IW'(1);
               state_in = mec_pkg::S_CK_A;
            end
         end
         mec_pkg::S_NEXT: begin
            if (!tri_ff) begin
               if (j_w + AW'(1) < cnt_w) begin
                  j_in = j_ff + IW'(1);
                  state_in = mec_pkg::S_PR_A;
               end else if (i_w + AW'(2) < cnt_w) begin
                  i_in = i_ff + IW'(1);
                  j_in = i_ff + IW'(2);
                  state_in = mec_pkg::S_PR_A;
               end else if (cnt_w >= AW'(3)) begin
                  tri_in = 1'b1;
                  i_in = '0;
                  j_in = IW'(1);
                  k_in = IW'(2);
                  state_in = mec_pkg::S_TR_A;
               end else begin
                  state_in = mec_pkg::S_SQRT;
               end
            end else begin
               if (k_w + AW'(1) < cnt_w) begin
                  k_in = k_ff + IW'(1);
                  state_in = mec_pkg::S_TR_A;
               end else if (j_w + AW'(2) < cnt_w) begin
                  j_in = j_ff + IW'(1);
                  k_in = j_ff + IW'(2);
                  state_in = mec_pkg::S_TR_A;
               end else if (i_w + AW'(3) < cnt_w) begin
                  i_in = i_ff + IW'(1);
                  j_in = i_ff + IW'(2);
                  k_in = i_ff + IW'(3);
                  state_in = mec_pkg::S_TR_A;
               end else begin
                  state_in = mec_pkg::S_SQRT;
               end
            end
         end
         mec_pkg::S_TR_A: state_in = mec_pkg::S_TR_B;
         mec_pkg::S_TR_B: state_in = mec_pkg::S_TR_C;
         mec_pkg::S_TR_C: state_in = mec_pkg::S_TR_D;
         mec_pkg::S_TR_D: state_in = mec_pkg::S_TR_E;
         mec_pkg::S_TR_E: state_in = mec_pkg::S_TR_F;
         mec_pkg::S_TR_F: state_in = mec_pkg::S_TR_G;
         mec_pkg::S_TR_G: state_in = mec_pkg::S_TR_H;
         mec_pkg::S_TR_H: state_in = mec_pkg::S_TR_I;
         mec_pkg::S_TR_I: state_in = sts.d_zero ? mec_pkg::S_NEXT : mec_pkg::S_TR_J;
         mec_pkg::S_TR_J: state_in = mec_pkg::S_TR_K;
         mec_pkg::S_TR_K: state_in = mec_pkg::S_TR_L;
         mec_pkg::S_TR_L: state_in = mec_pkg::S_TR_M;
         mec_pkg::S_TR_M: if (!sts.div_busy) state_in = mec_pkg::S_TR_N;
         mec_pkg::S_TR_N: state_in = sts.cand_ok ? mec_pkg::S_TR_O : mec_pkg::S_NEXT;
         mec_pkg::S_TR_O: state_in = mec_pkg::S_TR_P;
         mec_pkg::S_TR_P: state_in = mec_pkg::S_TR_Q;
         mec_pkg::S_TR_Q: state_in = mec_pkg::S_TR_R;
         mec_pkg::S_TR_R: if (!sts.div_busy) state_in = mec_pkg::S_TR_S;
         mec_pkg::S_TR_S: state_in = sts.cand_ok ? mec_pkg::S_TR_T : mec_pkg::S_NEXT;
         mec_pkg::S_TR_T: state_in = mec_pkg::S_TR_U;
         mec_pkg::S_TR_U: state_in = mec_pkg::S_TR_V;
         mec_pkg::S_TR_V: state_in = mec_pkg::S_CHK;
         mec_pkg::S_SQRT: state_in = mec_pkg::S_SQ_W;
         mec_pkg::S_SQ_W: if (!sts.sqrt_busy) state_in = mec_pkg::S_OUT;
         mec_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               count_in = '0;
               state_in = mec_pkg::S_LOAD;
            end
         end
         default: state_in = mec_pkg::S_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      rd_addr   = i_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IW-1:0];
      req_stall = 1'b1;
      unique case (state_ff)
         mec_pkg::S_LOAD: begin
            req_stall = 1'b0;
            wr_en = req_valid && (count_ff < MAX_CNT);
         end
         mec_pkg::S_START: begin
            rd_addr = '0;
            cmd.best_clr = 1'b1;
         end
         mec_pkg::S_ONE:   cmd.ld_i = 1'b1;
         mec_pkg::S_ONE_B: cmd.best_one = 1'b1;
         mec_pkg::S_PR_A:  rd_addr = i_ff;
         mec_pkg::S_PR_B: begin
            cmd.ld_i = 1'b1;
            rd_addr = j_ff;
         end
         mec_pkg::S_PR_C: cmd.ld_j = 1'b1;
         mec_pkg::S_PR_D: cmd.cand_pair = 1'b1;
         mec_pkg::S_PR_E: cmd.mul_op = mec_pkg::MUL_DI;
         mec_pkg::S_PR_F: begin
            cmd.r2_ld = 1'b1;
            cmd.mul_op = mec_pkg::MUL_DJ;
         end
         mec_pkg::S_PR_G: cmd.r2_max = 1'b1;
         mec_pkg::S_CK_A: rd_addr = m_ff;
         mec_pkg::S_CK_B: cmd.mul_op = mec_pkg::MUL_DM;
         mec_pkg::S_CK_C: cmd.best_upd = !sts.p_gt_r2 && m_last;
         mec_pkg::S_TR_A: rd_addr = i_ff;
         mec_pkg::S_TR_B: begin
            cmd.ld_i = 1'b1;
            rd_addr = j_ff;
         end
         mec_pkg::S_TR_C: begin
            cmd.ld_j = 1'b1;
            rd_addr = k_ff;
         end
         mec_pkg::S_TR_D: cmd.ld_k = 1'b1;
         mec_pkg::S_TR_E: cmd.mul_op = mec_pkg::MUL_B;
         mec_pkg::S_TR_F: begin
            cmd.b_ld = 1'b1;
            cmd.mul_op = mec_pkg::MUL_C;
         end
         mec_pkg::S_TR_G: begin
            cmd.c_ld = 1'b1;
            cmd.mul_op = mec_pkg::MUL_D;
         end
         mec_pkg::S_TR_H: cmd.d_ld = 1'b1;
         mec_pkg::S_TR_I: cmd.mul_op = mec_pkg::MUL_NXH;
         mec_pkg::S_TR_J: begin
            cmd.acc_op = mec_pkg::ACC_HI;
            cmd.mul_op = mec_pkg::MUL_NXL;
         end
         mec_pkg::S_TR_K: cmd.acc_op = mec_pkg::ACC_ADD;
         mec_pkg::S_TR_L: cmd.div_start = 1'b1;
         mec_pkg::S_TR_M: cmd.cand_x_ld = !sts.div_busy;
         mec_pkg::S_TR_N: cmd.mul_op = mec_pkg::MUL_NYH;
         mec_pkg::S_TR_O: begin
            cmd.acc_op = mec_pkg::ACC_HI;
            cmd.mul_op = mec_pkg::MUL_NYL;
         end
         mec_pkg::S_TR_P: cmd.acc_op = mec_pkg::ACC_ADD;
         mec_pkg::S_TR_Q: cmd.div_start = 1'b1;
         mec_pkg::S_TR_R: cmd.cand_y_ld = !sts.div_busy;
         mec_pkg::S_TR_S: cmd.mul_op = mec_pkg::MUL_DI;
         mec_pkg::S_TR_T: begin
            cmd.r2_ld = 1'b1;
            cmd.mul_op = mec_pkg::MUL_DJ;
         end
         mec_pkg::S_TR_U: begin
            cmd.r2_max = 1'b1;
            cmd.mul_op = mec_pkg::MUL_DK;
         end
         mec_pkg::S_TR_V: cmd.r2_max = 1'b1;
         mec_pkg::S_SQRT: cmd.sqrt_start = 1'b1;
         mec_pkg::S_OUT:  cmd.rsp_ld = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mec_pkg::S_OUT))
      else $error("result raised outside output state");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("point count above store depth");

   a_tri_order: assert property (@(posedge clock) disable iff (reset)
      (tri_ff && state_ff == mec_pkg::S_TR_E) |-> (i_ff < j_ff && j_ff < k_ff))
      else $error("triple indices out of order");

endmodule

// ===== rtl/min_enclosing_circle.sv =====
// Minimum enclosing circle, brute force. Points are taken one word per cycle
// while loading (signed Q8.8 x/y) into a point store of MAX_POINTS entries
// until a word marked last arrives; words beyond the store depth are
// dropped. The search then runs with req_stall high, over every pair and
// every triple (two 17-step divisions for the circumcenter, skipped for a
// collinear triple); each candidate smaller than the best so far is then
// checked against the stored points, all driven by one shared two-product
// multiplier and one point store read port. A square root ends the search
// and one result word is issued per set. The next set may start loading
// while that result still waits on rsp_stall.
module min_enclosing_circle #(
   parameter int MAX_POINTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mec_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mec_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_POINTS);

   mec_pkg::cmd_type cmd;
   mec_pkg::sts_type sts;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [IW-1:0]    rd_addr;

   mec_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_point),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   mec_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .rsp_data (rsp_data)
   );

endmodule
